### design/periodic_oneshot_timer_bank_top_assert.svh
// ----------------------------------------------------------------------------
// Timer bank assertion macros
// Concurrent assertion wrappers shared by the timer bank RTL; they expand to
// nothing when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef PERIODIC_ONESHOT_TIMER_BANK_TOP_ASSERT_SVH
`define PERIODIC_ONESHOT_TIMER_BANK_TOP_ASSERT_SVH

`ifndef SYNTH

// Check a property on every clock edge outside reset
`define POTB_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("timer bank assertion failed");

// Check that a condition implies a consequence in the same cycle
`define POTB_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("timer bank implication failed");

`else

`define POTB_ASSERT(label, clk, rst, prop)
`define POTB_ASSERT_IMP(label, clk, rst, ante, cons)

`endif

`endif

### design/potb_pkg.sv
// ----------------------------------------------------------------------------
// potb_pkg
// Shared types, codes and defaults of the periodic/one-shot timer bank.
// ----------------------------------------------------------------------------
`default_nettype none

package potb_pkg;

   // Default parameter values
   localparam int DEF_NUM_CHANNELS = 16;
   localparam int DEF_TICK_WIDTH   = 32;

   // Fixed field widths of the request and response words
   localparam int FUNC_W   = 3;
   localparam int INDEX_W  = 4;
   localparam int FIELD_W  = 32;
   localparam int STATUS_W = 3;

   // Most fire responses one tick may produce
   localparam int MAX_FIRES = 16;

   // Command codes
   localparam logic [FUNC_W-1:0] FUNC_INIT      = 3'd0;
   localparam logic [FUNC_W-1:0] FUNC_START     = 3'd1;
   localparam logic [FUNC_W-1:0] FUNC_STOP      = 3'd2;
   localparam logic [FUNC_W-1:0] FUNC_HARD_TICK = 3'd3;
   localparam logic [FUNC_W-1:0] FUNC_SOFT_TICK = 3'd4;

   // Channel status codes
   localparam logic [STATUS_W-1:0] ST_UNUSED  = 3'd0;
   localparam logic [STATUS_W-1:0] ST_CREATED = 3'd1;
   localparam logic [STATUS_W-1:0] ST_STARTED = 3'd2;
   localparam logic [STATUS_W-1:0] ST_RUNNING = 3'd3;
   localparam logic [STATUS_W-1:0] ST_STOPPED = 3'd4;

   // Request word
   typedef struct packed {
      logic [FUNC_W-1:0]  func;
      logic [INDEX_W-1:0] timer_index;
      logic [FIELD_W-1:0] start_delay;
      logic [FIELD_W-1:0] period;
      logic               hard_class;
   } req_word_type;

   // Response word
   typedef struct packed {
      logic [INDEX_W-1:0] fired_channel;
      logic               went_stopped;
      logic               last;
   } rsp_word_type;

   // Controller to datapath commands
   typedef struct packed {
      logic accept;
      logic do_init;
      logic do_stop;
      logic tick_go;
      logic start_load;
      logic walk_rd;
      logic walk_skip;
      logic upd_commit;
      logic flush_push;
   } ctl_cmd_type;

   // Datapath to controller status
   typedef struct packed {
      logic is_init;
      logic is_start;
      logic is_stop;
      logic is_tick;
      logic idx_ok;
      logic start_ok;
      logic stop_ok;
      logic scan_done;
      logic scan_sel;
      logic upd_fire;
      logic pend_v;
      logic out_free;
   } dp_stat_type;

endpackage

`default_nettype wire

### design/potb_channel_if.sv
// ----------------------------------------------------------------------------
// potb_channel_if
// Valid/ready channels of the timer bank: request and response.
// ----------------------------------------------------------------------------
`default_nettype none

interface potb_req_if;
   logic                             valid;
   logic                             ready;
   logic [potb_pkg::FUNC_W-1:0]      func;
   logic [potb_pkg::INDEX_W-1:0]     timer_index;
   logic [potb_pkg::FIELD_W-1:0]     start_delay;
   logic [potb_pkg::FIELD_W-1:0]     period;
   logic                             hard_class;

   modport source (output valid, output func, output timer_index, output start_delay,
                   output period, output hard_class, input ready);
   modport sink   (input valid, input func, input timer_index, input start_delay,
                   input period, input hard_class, output ready);
endinterface

interface potb_rsp_if;
   logic                             valid;
   logic                             ready;
   logic [potb_pkg::INDEX_W-1:0]     fired_channel;
   logic                             went_stopped;
   logic                             last;

   modport source (output valid, output fired_channel, output went_stopped,
                   output last, input ready);
   modport sink   (input valid, input fired_channel, input went_stopped,
                   input last, output ready);
endinterface

`default_nettype wire

### design/potb_ram.sv
// ----------------------------------------------------------------------------
// potb_ram
// Generic one-write, one-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module potb_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  wire logic                                  clock,
   input  wire logic                                  wr_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]                      wr_data,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output      logic [WIDTH-1:0]                      rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port
   always_ff @(posedge clock) begin
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

### design/potb_ctl.sv
// ----------------------------------------------------------------------------
// potb_ctl
// Sequencer of the timer bank: takes one request word at a time and steps the
// datapath through start loads and tick walks.
// ----------------------------------------------------------------------------
`default_nettype none

module potb_ctl (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output      logic                  req_ready,
   input  wire potb_pkg::dp_stat_type stat,
   output      potb_pkg::ctl_cmd_type cmd
);

`include "periodic_oneshot_timer_bank_top_assert.svh"

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_START = 3'd1;
   localparam logic [2:0] S_SCAN  = 3'd2;
   localparam logic [2:0] S_UPD   = 3'd3;
   localparam logic [2:0] S_FLUSH = 3'd4;

   logic [2:0] state_ff;
   logic [2:0] state_in;

   // Next state and commands
   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.accept = 1'b1;
               if (stat.is_init && stat.idx_ok) begin
                  cmd.do_init = 1'b1;
               end
               if (stat.is_start && stat.idx_ok && stat.start_ok) begin
                  state_in = S_START;
               end
               if (stat.is_stop && stat.idx_ok && stat.stop_ok) begin
                  cmd.do_stop = 1'b1;
               end
               if (stat.is_tick) begin
                  cmd.tick_go = 1'b1;
                  state_in    = S_SCAN;
               end
            end
         end
         S_START: begin
            cmd.start_load = 1'b1;
            state_in       = S_IDLE;
         end
         S_SCAN: begin
            cmd.walk_rd = 1'b1;
            if (stat.scan_done) begin
               state_in = S_FLUSH;
            end else if (stat.scan_sel) begin
               state_in = S_UPD;
            end else begin
               cmd.walk_skip = 1'b1;
            end
         end
         S_UPD: begin
            cmd.walk_rd = 1'b1;
            // hold while an earlier fire waits for the output slot
            if (!(stat.upd_fire && stat.pend_v && !stat.out_free)) begin
               cmd.upd_commit = 1'b1;
               state_in       = S_SCAN;
            end
         end
         S_FLUSH: begin
            if (!stat.pend_v) begin
               state_in = S_IDLE;
            end else if (stat.out_free) begin
               cmd.flush_push = 1'b1;
               state_in       = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   `POTB_ASSERT_IMP(a_start_from_idle, clock, reset,
                    state_ff == S_START, $past(state_ff) == S_IDLE)
   `POTB_ASSERT(a_one_walk_step, clock, reset,
                $onehot0({cmd.walk_skip, cmd.upd_commit, cmd.flush_push,
                          cmd.start_load, cmd.accept}))
   `POTB_ASSERT(a_ready_in_idle, clock, reset, req_ready == (state_ff == S_IDLE))

endmodule

`default_nettype wire

### design/potb_datapath.sv
// ----------------------------------------------------------------------------
// potb_datapath
// Channel stores, countdown update, fire pending stage and response register.
// ----------------------------------------------------------------------------
`default_nettype none

module potb_datapath #(
   parameter int NUM_CHANNELS = potb_pkg::DEF_NUM_CHANNELS,
   parameter int TICK_WIDTH   = potb_pkg::DEF_TICK_WIDTH
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire potb_pkg::req_word_type req_word,
   input  wire potb_pkg::ctl_cmd_type  cmd,
   output      potb_pkg::dp_stat_type  stat,
   output      logic                   rsp_valid,
   input  wire logic                   rsp_ready,
   output      potb_pkg::rsp_word_type rsp_word
);

`include "periodic_oneshot_timer_bank_top_assert.svh"

   localparam int ChW   = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
   localparam int WalkW = ChW + 1;
   localparam int CmpW  = ((ChW > potb_pkg::INDEX_W) ? ChW : potb_pkg::INDEX_W) + 1;
   localparam int FireW = $clog2(potb_pkg::MAX_FIRES + 1);
   localparam int CfgW  = 2 * TICK_WIDTH;

   // Per-channel status and class
   logic [potb_pkg::STATUS_W-1:0] status_ff [NUM_CHANNELS];
   logic                          class_ff  [NUM_CHANNELS];

   // Walk and fire bookkeeping
   logic [WalkW-1:0] walk_ff, walk_in;
   logic [FireW-1:0] fires_ff, fires_in;
   logic             want_ff, want_in;
   logic [ChW-1:0]   idx_ff, idx_in;

   // Pending fire and response register
   logic                          pend_v_ff, pend_v_in;
   logic [potb_pkg::INDEX_W-1:0]  pend_ch_ff, pend_ch_in;
   logic                          pend_stop_ff, pend_stop_in;
   logic                          out_v_ff, out_v_in;
   logic [potb_pkg::INDEX_W-1:0]  out_ch_ff, out_ch_in;
   logic                          out_stop_ff, out_stop_in;
   logic                          out_last_ff, out_last_in;

   // RAM ports
   logic [ChW-1:0]        rd_addr;
   logic [CfgW-1:0]       cfg_wr_data, cfg_rd_data;
   logic                  cnt_wr_en;
   logic [ChW-1:0]        cnt_wr_addr;
   logic [TICK_WIDTH-1:0] cnt_wr_data, cnt_rd_data;

   // Decoded values
   logic [CmpW-1:0]               idx_ext, walk_ext;
   logic [ChW-1:0]                idx_addr, walk_addr;
   logic [TICK_WIDTH-1:0]         req_delay, req_period, req_first;
   logic [TICK_WIDTH-1:0]         cfg_delay, cfg_period, cfg_first, cnt_dec;
   logic                          upd_fire, out_free, push_mid, out_load;
   logic [potb_pkg::STATUS_W-1:0] idx_st, walk_st;

   // Decode request index and operands
   assign idx_ext    = CmpW'(req_word.timer_index);
   assign idx_addr   = idx_ext[ChW-1:0];
   assign walk_ext   = CmpW'(walk_ff);
   assign walk_addr  = walk_ff[ChW-1:0];
   assign req_delay  = TICK_WIDTH'(req_word.start_delay);
   assign req_period = TICK_WIDTH'(req_word.period);
   assign req_first  = (req_delay != '0) ? req_delay : req_period;
   assign cfg_wr_data = {req_period, req_delay};
   assign cfg_delay  = cfg_rd_data[TICK_WIDTH-1:0];
   assign cfg_period = cfg_rd_data[CfgW-1:TICK_WIDTH];
   assign cfg_first  = (cfg_delay != '0) ? cfg_delay : cfg_period;
   assign cnt_dec    = cnt_rd_data - TICK_WIDTH'(1);
   assign upd_fire   = (cnt_dec == '0);
   assign idx_st     = status_ff[idx_addr];
   assign walk_st    = status_ff[walk_addr];
   assign rd_addr    = cmd.walk_rd ? walk_addr : idx_addr;
   assign out_free   = !out_v_ff || rsp_ready;
   assign push_mid   = cmd.upd_commit && upd_fire && pend_v_ff;
   assign out_load   = push_mid || cmd.flush_push;

   // Status toward the controller
   always_comb begin
      stat.is_init   = (req_word.func == potb_pkg::FUNC_INIT);
      stat.is_start  = (req_word.func == potb_pkg::FUNC_START);
      stat.is_stop   = (req_word.func == potb_pkg::FUNC_STOP);
      stat.is_tick   = (req_word.func == potb_pkg::FUNC_HARD_TICK) ||
                       (req_word.func == potb_pkg::FUNC_SOFT_TICK);
      stat.idx_ok    = (idx_ext < CmpW'(NUM_CHANNELS));
      stat.start_ok  = (idx_st == potb_pkg::ST_CREATED) || (idx_st == potb_pkg::ST_STOPPED);
      stat.stop_ok   = (idx_st == potb_pkg::ST_STARTED) || (idx_st == potb_pkg::ST_RUNNING);
      stat.scan_done = (walk_ff == WalkW'(NUM_CHANNELS)) ||
                       (fires_ff == FireW'(potb_pkg::MAX_FIRES));
      stat.scan_sel  = ((walk_st == potb_pkg::ST_STARTED) ||
                        (walk_st == potb_pkg::ST_RUNNING)) && (class_ff[walk_addr] == want_ff);
      stat.upd_fire  = upd_fire;
      stat.pend_v    = pend_v_ff;
      stat.out_free  = out_free;
   end

   // Countdown write source: init, start reload or tick update
   always_comb begin
      cnt_wr_en   = 1'b0;
      cnt_wr_addr = idx_addr;
      cnt_wr_data = req_first;
      if (cmd.do_init) begin
         cnt_wr_en = 1'b1;
      end else if (cmd.start_load) begin
         cnt_wr_en   = 1'b1;
         cnt_wr_addr = idx_ff;
         cnt_wr_data = cfg_first;
      end else if (cmd.upd_commit) begin
         cnt_wr_en   = 1'b1;
         cnt_wr_addr = walk_addr;
         cnt_wr_data = (upd_fire && (cfg_period != '0)) ? cfg_period : cnt_dec;
      end
   end

   potb_ram #(
      .WIDTH (CfgW),
      .DEPTH (NUM_CHANNELS)
   ) u_cfg_ram (
      .clock   (clock),
      .wr_en   (cmd.do_init),
      .wr_addr (idx_addr),
      .wr_data (cfg_wr_data),
      .rd_addr (rd_addr),
      .rd_data (cfg_rd_data)
   );

   potb_ram #(
      .WIDTH (TICK_WIDTH),
      .DEPTH (NUM_CHANNELS)
   ) u_cnt_ram (
      .clock   (clock),
      .wr_en   (cnt_wr_en),
      .wr_addr (cnt_wr_addr),
      .wr_data (cnt_wr_data),
      .rd_addr (rd_addr),
      .rd_data (cnt_rd_data)
   );

   // Channel status updates
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_CHANNELS; i++) begin
            status_ff[i] <= potb_pkg::ST_UNUSED;
         end
      end else begin
         if (cmd.do_init) begin
            status_ff[idx_addr] <= potb_pkg::ST_CREATED;
         end
         if (cmd.do_stop) begin
            status_ff[idx_addr] <= potb_pkg::ST_STOPPED;
         end
         if (cmd.start_load) begin
            status_ff[idx_ff] <= potb_pkg::ST_STARTED;
         end
         if (cmd.upd_commit && upd_fire) begin
            status_ff[walk_addr] <= (cfg_period != '0) ? potb_pkg::ST_RUNNING
                                                       : potb_pkg::ST_STOPPED;
         end
      end
   end

   // Channel class, written by init only
   always_ff @(posedge clock) begin
      if (cmd.do_init) begin
         class_ff[idx_addr] <= req_word.hard_class;
      end
   end

   // Walk, pending fire and response next values
   always_comb begin
      walk_in      = walk_ff;
      fires_in     = fires_ff;
      want_in      = want_ff;
      idx_in       = idx_ff;
      pend_v_in    = pend_v_ff;
      pend_ch_in   = pend_ch_ff;
      pend_stop_in = pend_stop_ff;
      out_v_in     = out_v_ff;
      out_ch_in    = out_ch_ff;
      out_stop_in  = out_stop_ff;
      out_last_in  = out_last_ff;

      if (cmd.accept) begin
         idx_in = idx_addr;
      end
      if (cmd.tick_go) begin
         walk_in   = '0;
         fires_in  = '0;
         want_in   = (req_word.func == potb_pkg::FUNC_HARD_TICK);
         pend_v_in = 1'b0;
      end
      if (cmd.walk_skip || cmd.upd_commit) begin
         walk_in = walk_ff + WalkW'(1);
      end

      // drop the drained pending word into the response register
      if (out_load) begin
         out_v_in    = 1'b1;
         out_ch_in   = pend_ch_ff;
         out_stop_in = pend_stop_ff;
         out_last_in = cmd.flush_push;
      end else if (rsp_ready) begin
         out_v_in = 1'b0;
      end

      // hold the newest fire until the next one or the end of the walk
      if (cmd.upd_commit && upd_fire) begin
         fires_in     = fires_ff + FireW'(1);
         pend_v_in    = 1'b1;
         pend_ch_in   = walk_ext[potb_pkg::INDEX_W-1:0];
         pend_stop_in = (cfg_period == '0);
      end
      if (cmd.flush_push) begin
         pend_v_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         walk_ff   <= '0;
         fires_ff  <= '0;
         want_ff   <= 1'b0;
         idx_ff    <= '0;
         pend_v_ff <= 1'b0;
         out_v_ff  <= 1'b0;
      end else begin
         walk_ff   <= walk_in;
         fires_ff  <= fires_in;
         want_ff   <= want_in;
         idx_ff    <= idx_in;
         pend_v_ff <= pend_v_in;
         out_v_ff  <= out_v_in;
      end
   end

   always_ff @(posedge clock) begin
      pend_ch_ff   <= pend_ch_in;
      pend_stop_ff <= pend_stop_in;
      out_ch_ff    <= out_ch_in;
      out_stop_ff  <= out_stop_in;
      out_last_ff  <= out_last_in;
   end

   assign rsp_valid              = out_v_ff;
   assign rsp_word.fired_channel = out_ch_ff;
   assign rsp_word.went_stopped  = out_stop_ff;
   assign rsp_word.last          = out_last_ff;

   `POTB_ASSERT_IMP(a_push_needs_slot, clock, reset, out_load, out_free)
   `POTB_ASSERT(a_fire_bound, clock, reset, fires_ff <= FireW'(potb_pkg::MAX_FIRES))
   `POTB_ASSERT_IMP(a_commit_in_range, clock, reset, cmd.upd_commit, walk_ff < WalkW'(NUM_CHANNELS))

endmodule

`default_nettype wire

### design/periodic_oneshot_timer_bank_top.sv
// ----------------------------------------------------------------------------
// periodic_oneshot_timer_bank_top
// Bank of countdown timer channels driven by init, start, stop and tick words.
//
// Each request word is one command. Init, stop and unknown commands complete
// as the word is accepted; start reads the channel's stored delay and period,
// then writes the countdown. A hard or soft tick is accepted, then walks the
// channels in ascending order through the countdown and configuration RAMs:
// a channel outside the ticked class or not armed is skipped in the scan
// state, an armed one is read in the scan state and then updated in the
// update state, which waits while an earlier fire still waits for the output
// slot, and a flush state closes the walk.
// Each channel that reaches zero gives one response word; the word with last
// set closes the tick. A tick with no expiry gives no word. The response sits
// in an output register, so the next request word is taken while the final
// response of a tick still waits to be read.
// ----------------------------------------------------------------------------
`default_nettype none

module periodic_oneshot_timer_bank_top #(
   parameter int NUM_CHANNELS = potb_pkg::DEF_NUM_CHANNELS,
   parameter int TICK_WIDTH   = potb_pkg::DEF_TICK_WIDTH
) (
   input wire logic   clock,
   input wire logic   reset,
   potb_req_if.sink   req_ch,
   potb_rsp_if.source rsp_ch
);

   potb_pkg::req_word_type req_word;
   potb_pkg::rsp_word_type rsp_word;
   potb_pkg::ctl_cmd_type  cmd;
   potb_pkg::dp_stat_type  stat;
   logic                   req_ready;
   logic                   rsp_valid;

   // Pack the request word
   always_comb begin
      req_word.func        = req_ch.func;
      req_word.timer_index = req_ch.timer_index;
      req_word.start_delay = req_ch.start_delay;
      req_word.period      = req_ch.period;
      req_word.hard_class  = req_ch.hard_class;
   end

   potb_ctl u_ctl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   potb_datapath #(
      .NUM_CHANNELS (NUM_CHANNELS),
      .TICK_WIDTH   (TICK_WIDTH)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_word  (req_word),
      .cmd       (cmd),
      .stat      (stat),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ch.ready),
      .rsp_word  (rsp_word)
   );

   // Drive the channel ports
   assign req_ch.ready         = req_ready;
   assign rsp_ch.valid         = rsp_valid;
   assign rsp_ch.fired_channel = rsp_word.fired_channel;
   assign rsp_ch.went_stopped  = rsp_word.went_stopped;
   assign rsp_ch.last          = rsp_word.last;

endmodule

`default_nettype wire

### sim/periodic_oneshot_timer_bank_checker.sv
// ----------------------------------------------------------------------------
// Timer bank checker
// Watches the command and fire channels of the timer bank. It keeps its own
// copy of every channel's delay, period, countdown, status and class, works
// out the fire words each accepted command causes, and compares every
// accepted fire word field by field with the oldest one still waiting.
// ----------------------------------------------------------------------------
module periodic_oneshot_timer_bank_checker #(
   parameter int NUM_CHANNELS = potb_pkg::DEF_NUM_CHANNELS,
   parameter int TICK_WIDTH   = potb_pkg::DEF_TICK_WIDTH
) (
   input  wire logic clock,
   input  wire logic reset,
   potb_req_if       req_mon,
   potb_rsp_if       rsp_mon,
   output int        mismatch_count,
   output int        fires_waiting,
   output int        fires_checked
);
   timeunit 1ns;
   timeprecision 1ps;

   // Shadow copy of the bank
   logic [TICK_WIDTH-1:0]         delay_mem  [NUM_CHANNELS];
   logic [TICK_WIDTH-1:0]         period_mem [NUM_CHANNELS];
   logic [TICK_WIDTH-1:0]         count_mem  [NUM_CHANNELS];
   logic [potb_pkg::STATUS_W-1:0] state_mem  [NUM_CHANNELS];
   logic                          class_mem  [NUM_CHANNELS];

   // Fire words still owed by the block, oldest first
   potb_pkg::rsp_word_type fire_queue [$];

   int error_total   = 0;
   int checked_total = 0;

   function automatic logic chan_armed(int ch);
      return state_mem[ch] == potb_pkg::ST_STARTED || state_mem[ch] == potb_pkg::ST_RUNNING;
   endfunction

   // Start delay if nonzero, else the period
   function automatic logic [TICK_WIDTH-1:0] load_value(int ch);
      return (delay_mem[ch] != '0) ? delay_mem[ch] : period_mem[ch];
   endfunction

   // Advance the shadow bank by one command word and queue its fire words
   task automatic advance_bank(input potb_pkg::req_word_type cmd);
      int                     ch;
      int                     n_fired;
      logic                   want_hard;
      potb_pkg::rsp_word_type fw;
      ch      = int'(cmd.timer_index);
      n_fired = 0;
      case (cmd.func)
         potb_pkg::FUNC_INIT: begin
            if (ch < NUM_CHANNELS) begin
               delay_mem[ch]  = TICK_WIDTH'(cmd.start_delay);
               period_mem[ch] = TICK_WIDTH'(cmd.period);
               class_mem[ch]  = cmd.hard_class;
               state_mem[ch]  = potb_pkg::ST_CREATED;
               count_mem[ch]  = load_value(ch);
            end
         end
         potb_pkg::FUNC_START: begin
            if (ch < NUM_CHANNELS &&
                (state_mem[ch] == potb_pkg::ST_CREATED ||
                 state_mem[ch] == potb_pkg::ST_STOPPED)) begin
               state_mem[ch] = potb_pkg::ST_STARTED;
               count_mem[ch] = load_value(ch);
            end
         end
         potb_pkg::FUNC_STOP: begin
            if (ch < NUM_CHANNELS && chan_armed(ch))
               state_mem[ch] = potb_pkg::ST_STOPPED;
         end
         potb_pkg::FUNC_HARD_TICK, potb_pkg::FUNC_SOFT_TICK: begin
            want_hard = (cmd.func == potb_pkg::FUNC_HARD_TICK);
            // Walk channels in ascending order; a zero countdown wraps silently
            for (int i = 0; i < NUM_CHANNELS && n_fired < potb_pkg::MAX_FIRES; i++) begin
               if (chan_armed(i) && class_mem[i] == want_hard) begin
                  count_mem[i] = count_mem[i] - 1'b1;
                  if (count_mem[i] == '0) begin
                     fw.fired_channel = potb_pkg::INDEX_W'(i);
                     fw.went_stopped  = (period_mem[i] == '0);
                     fw.last          = 1'b0;
                     if (period_mem[i] != '0) begin
                        state_mem[i] = potb_pkg::ST_RUNNING;
                        count_mem[i] = period_mem[i];
                     end else begin
                        state_mem[i] = potb_pkg::ST_STOPPED;
                     end
                     fire_queue.push_back(fw);
                     n_fired++;
                  end
               end
            end
            // Mark the closing word of this tick
            if (n_fired > 0) begin
               fw      = fire_queue.pop_back();
               fw.last = 1'b1;
               fire_queue.push_back(fw);
            end
         end
         default: ;
      endcase
   endtask

   always @(posedge clock) begin
      potb_pkg::req_word_type cmd;
      potb_pkg::rsp_word_type want;
      if (reset) begin
         fire_queue.delete();
         for (int i = 0; i < NUM_CHANNELS; i++) begin
            state_mem[i]  = potb_pkg::ST_UNUSED;
            delay_mem[i]  = '0;
            period_mem[i] = '0;
            count_mem[i]  = '0;
            class_mem[i]  = 1'b0;
         end
      end else begin
         // Check the fire word first: it can never belong to a command taken now
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (fire_queue.size() == 0) begin
               $error("unexpected fire word: fired_channel %0d went_stopped %0d last %0d",
                      rsp_mon.fired_channel, rsp_mon.went_stopped, rsp_mon.last);
               error_total++;
            end else begin
               want = fire_queue.pop_front();
               if (rsp_mon.fired_channel !== want.fired_channel) begin
                  $error("fired_channel mismatch: expected %0d, actual %0d",
                         want.fired_channel, rsp_mon.fired_channel);
                  error_total++;
               end
               if (rsp_mon.went_stopped !== want.went_stopped) begin
                  $error("went_stopped mismatch: expected %0d, actual %0d",
                         want.went_stopped, rsp_mon.went_stopped);
                  error_total++;
               end
               if (rsp_mon.last !== want.last) begin
                  $error("last mismatch: expected %0d, actual %0d",
                         want.last, rsp_mon.last);
                  error_total++;
               end
               checked_total++;
            end
         end
         // Predict from the accepted command word
         if (req_mon.valid && req_mon.ready) begin
            cmd.func        = req_mon.func;
            cmd.timer_index = req_mon.timer_index;
            cmd.start_delay = req_mon.start_delay;
            cmd.period      = req_mon.period;
            cmd.hard_class  = req_mon.hard_class;
            advance_bank(cmd);
         end
      end
      mismatch_count <= error_total;
      fires_waiting  <= fire_queue.size();
      fires_checked  <= checked_total;
   end

endmodule

### sim/periodic_oneshot_timer_bank_top_tb.sv
// ----------------------------------------------------------------------------
// Timer bank testbench
// Drives command words into the timer bank: a directed opening over idle
// channels, unknown commands, one-shot and periodic channels, zero and full
// scale counts and re-init of an armed channel, then a 16-way fire and
// biased random traffic. Both channel sides stall in random bursts; the
// checker beside the block predicts and compares the fire words.
// ----------------------------------------------------------------------------
module periodic_oneshot_timer_bank_top_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int NUM_CHANNELS = potb_pkg::DEF_NUM_CHANNELS;
   localparam int RANDOM_WORDS = 42;
   localparam int DRAIN_CYCLES = 4 * (2 * NUM_CHANNELS + 2);
   localparam int LIMIT_CYCLES = 500000;

   // Command codes outside the defined set
   localparam logic [potb_pkg::FUNC_W-1:0] FUNC_UNKNOWN_LO = potb_pkg::FUNC_SOFT_TICK + 3'd1;
   localparam logic [potb_pkg::FUNC_W-1:0] FUNC_UNKNOWN_HI = '1;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic idle_enable = 1'b1;

   int cycle_count = 0;
   int sent_words  = 0;
   int tick_words  = 0;
   int mismatch_count;
   int fires_waiting;
   int fires_checked;

   potb_req_if req_ch ();
   potb_rsp_if rsp_ch ();

   periodic_oneshot_timer_bank_top i_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   periodic_oneshot_timer_bank_checker i_checker (
      .clock          (clock),
      .reset          (reset),
      .req_mon        (req_ch),
      .rsp_mon        (rsp_ch),
      .mismatch_count (mismatch_count),
      .fires_waiting  (fires_waiting),
      .fires_checked  (fires_checked)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Abort a hung run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= LIMIT_CYCLES) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   // Stall the fire channel in random bursts while idling is on
   initial begin
      rsp_ch.ready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (idle_enable && $urandom_range(0, 7) == 0) begin
            rsp_ch.ready <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge clock);
         end
         rsp_ch.ready <= 1'b1;
         @(posedge clock);
      end
   end

   // Mostly short counts so channels fire often; now and then a full-width one
   function automatic logic [potb_pkg::FIELD_W-1:0] pick_ticks();
      if ($urandom_range(0, 7) == 0)
         return $urandom();
      return potb_pkg::FIELD_W'($urandom_range(0, 6));
   endfunction

   // Offer one command word and hold it until the block takes it
   task automatic send_command(input logic [potb_pkg::FUNC_W-1:0] func_code, input int chan,
                               input logic [potb_pkg::FIELD_W-1:0] delay,
                               input logic [potb_pkg::FIELD_W-1:0] reload, input logic hard);
      if (idle_enable && $urandom_range(0, 3) == 0) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 16)) @(posedge clock);
      end
      req_ch.valid       <= 1'b1;
      req_ch.func        <= func_code;
      req_ch.timer_index <= potb_pkg::INDEX_W'(chan);
      req_ch.start_delay <= delay;
      req_ch.period      <= reload;
      req_ch.hard_class  <= hard;
      do @(posedge clock); while (!req_ch.ready);
      sent_words++;
      if (func_code == potb_pkg::FUNC_HARD_TICK || func_code == potb_pkg::FUNC_SOFT_TICK)
         tick_words++;
   endtask

   // Biased random command: mostly init, start and ticks, a few stops and unknowns
   task automatic send_random_command();
      int                          pick;
      logic [potb_pkg::FUNC_W-1:0] f;
      pick = $urandom_range(0, 99);
      if (pick < 20)
         f = potb_pkg::FUNC_INIT;
      else if (pick < 40)
         f = potb_pkg::FUNC_START;
      else if (pick < 48)
         f = potb_pkg::FUNC_STOP;
      else if (pick < 72)
         f = potb_pkg::FUNC_HARD_TICK;
      else if (pick < 96)
         f = potb_pkg::FUNC_SOFT_TICK;
      else
         f = FUNC_UNKNOWN_LO + potb_pkg::FUNC_W'($urandom_range(0, 2));
      send_command(f, $urandom_range(0, NUM_CHANNELS - 1), pick_ticks(), pick_ticks(),
                   1'($urandom_range(0, 1)));
   endtask

   initial begin
      int n;
      req_ch.valid       <= 1'b0;
      req_ch.func        <= potb_pkg::FUNC_INIT;
      req_ch.timer_index <= '0;
      req_ch.start_delay <= '0;
      req_ch.period      <= '0;
      req_ch.hard_class  <= 1'b0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Start and stop on a channel that was never set up
      send_command(potb_pkg::FUNC_START, 0, '0, '0, 1'b0);
      send_command(potb_pkg::FUNC_STOP, 0, '0, '0, 1'b0);
      // Unknown commands
      send_command(FUNC_UNKNOWN_LO, 15, '1, '1, 1'b1);
      send_command(FUNC_UNKNOWN_LO + 3'd1, 7, 32'd5, 32'd5, 1'b0);
      send_command(FUNC_UNKNOWN_HI, 9, '0, '0, 1'b1);
      // Tick with nothing armed
      send_command(potb_pkg::FUNC_HARD_TICK, 0, '0, '0, 1'b0);
      // One-shot, period-only, all-zero and full-scale channels
      send_command(potb_pkg::FUNC_INIT, 0, 32'd1, '0, 1'b1);
      send_command(potb_pkg::FUNC_INIT, 15, '0, 32'd2, 1'b1);
      send_command(potb_pkg::FUNC_INIT, 3, '0, '0, 1'b0);
      send_command(potb_pkg::FUNC_INIT, 5, '1, '1, 1'b0);
      send_command(potb_pkg::FUNC_START, 0, '0, '0, 1'b0);
      send_command(potb_pkg::FUNC_START, 15, '0, '0, 1'b0);
      send_command(potb_pkg::FUNC_START, 3, '0, '0, 1'b0);
      send_command(potb_pkg::FUNC_START, 5, '0, '0, 1'b0);
      // Start on a started channel keeps its countdown
      send_command(potb_pkg::FUNC_START, 15, '0, '0, 1'b0);
      send_command(potb_pkg::FUNC_HARD_TICK, 0, '0, '0, 1'b0);
      send_command(potb_pkg::FUNC_HARD_TICK, 0, '0, '0, 1'b0);
      // Zero countdown wraps without firing
      send_command(potb_pkg::FUNC_SOFT_TICK, 0, '0, '0, 1'b0);
      // Stop a running channel, then once more while stopped
      send_command(potb_pkg::FUNC_STOP, 15, '0, '0, 1'b0);
      send_command(potb_pkg::FUNC_STOP, 15, '0, '0, 1'b0);
      send_command(potb_pkg::FUNC_START, 15, '0, '0, 1'b0);
      // Re-init of an armed channel disarms it
      send_command(potb_pkg::FUNC_INIT, 5, 32'd2, 32'd1, 1'b0);
      send_command(potb_pkg::FUNC_START, 5, '0, '0, 1'b0);
      send_command(potb_pkg::FUNC_SOFT_TICK, 0, '0, '0, 1'b0);
      send_command(potb_pkg::FUNC_SOFT_TICK, 0, '0, '0, 1'b0);

      // Arm every channel in the hard class so one tick fires all of them
      for (int ch = 0; ch < NUM_CHANNELS; ch++)
         send_command(potb_pkg::FUNC_INIT, ch, 32'd1,
                      potb_pkg::FIELD_W'($urandom_range(0, 3)), 1'b1);
      for (int ch = 0; ch < NUM_CHANNELS; ch++)
         send_command(potb_pkg::FUNC_START, ch, '0, '0, 1'b0);
      send_command(potb_pkg::FUNC_HARD_TICK, 0, '0, '0, 1'b0);

      // Random traffic; drop idling for the last stretch
      n = 0;
      while (n < RANDOM_WORDS) begin
         if (n >= RANDOM_WORDS * 4 / 5)
            idle_enable = 1'b0;
         send_random_command();
         n++;
      end
      req_ch.valid <= 1'b0;

      // Drain the fire words, then let any walk in flight finish
      @(posedge clock);
      while (fires_waiting != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Sent %0d command words (%0d ticks) and checked %0d fire words.",
               sent_words, tick_words, fires_checked);
      if (mismatch_count == 0 && fires_waiting == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule

### files.f
+incdir+design
design/potb_pkg.sv
design/potb_channel_if.sv
design/potb_ram.sv
design/potb_ctl.sv
design/potb_datapath.sv
design/periodic_oneshot_timer_bank_top.sv
sim/periodic_oneshot_timer_bank_checker.sv
sim/periodic_oneshot_timer_bank_top_tb.sv
